// ===== hw/rtl/swqt_pkg.sv =====
// Shared constants for the sliding-window quantile tracker.
// Holds register indexes, fixed-point constants and rank multipliers.
// Depends on nothing.
`default_nettype none

package swqt_pkg;

    localparam int NUM_Q      = 5;
    localparam int RANK_SHIFT = 24;
    localparam int CFG_IDX_W  = 8;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MED_THR     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_THR    = 8'd3;

    // ceil(pct * 2^24 / 100) for pct = 10, 25, 50, 75, 90
    function automatic logic [23:0] pct_mult(input logic [2:0] k);
        logic [23:0] m;
        begin
            case (k)
                3'd0: m = 24'd1677722;
                3'd1: m = 24'd4194304;
                3'd2: m = 24'd8388608;
                3'd3: m = 24'd12582912;
                3'd4: m = 24'd15099495;
                default: m = 24'd0;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module swqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_quantile_tracker_core.sv =====
// Sliding-window quantile tracker: window RAM, rank-count selection,
// skew divider and shift detection. Uses swqt_pkg and swqt_ram.
// Result timing: once the fill requirement is met, each result waits on the
//   single RAM read port scanned once per candidate plus a 48-step divider;
//   otherwise the sample goes straight to the output stage.
// Throughput: one item at a time; the next can be taken, at the earliest, the
//   cycle after the result moves to the output register.
// Reset: all control and held state set to defaults, window RAM is never cleared.
`default_nettype none

module sliding_window_quantile_tracker_core
    import swqt_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire logic signed [31:0]   sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic signed [31:0]        q10,
    output logic signed [31:0]        q25,
    output logic signed [31:0]        q50,
    output logic signed [31:0]        q75,
    output logic signed [31:0]        q90,
    output logic        [31:0]        skew_q16,
    output logic                      median_shift,
    output logic signed [31:0]        old_median,
    output logic                      skew_change,
    output logic        [31:0]        shift_count,
    output logic        [31:0]        sample_count,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = AW + 1;
    localparam int EW = (CW > 7) ? CW : 7;
    localparam logic [EW-1:0] MAXW = EW'(MAX_WINDOW);
    localparam logic [EW-1:0] MINW = EW'(8);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RANK  = 10'b00_0000_0010,
        S_CRD   = 10'b00_0000_0100,
        S_CCAP  = 10'b00_0000_1000,
        S_SCAN  = 10'b00_0001_0000,
        S_CEVAL = 10'b00_0010_0000,
        S_DINIT = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_SKEW  = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    logic [6:0]  win_size_reg;
    logic [6:0]  min_fill_reg;
    logic [30:0] med_thr_reg;
    logic [30:0] skew_thr_reg;

    logic [AW-1:0] wp_reg;
    logic [CW-1:0] fill_reg;
    logic          seeded_reg;
    logic signed [31:0] ref_med_reg;
    logic [31:0]   ref_skew_reg;
    logic signed [31:0] q_reg [NUM_Q];
    logic [31:0]   skew_reg;
    logic [31:0]   total_reg;
    logic [31:0]   shift_cnt_reg;

    logic [2:0]    k_reg;
    logic [CW-1:0] rank_reg [NUM_Q];
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] lt_reg;
    logic [CW-1:0] le_reg;
    logic signed [31:0] cand_reg;

    logic [32:0]   rem_reg;
    logic [47:0]   quo_reg;
    logic [32:0]   dvs_reg;
    logic [5:0]    dcnt_reg;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [EW-1:0] w_eff;
    logic [EW-1:0] need;
    logic [EW-1:0] fill_ext;
    logic [CW-1:0] fill_next;
    logic [EW-1:0] wp_inc;
    logic [AW-1:0] wp_next;
    logic          accept;
    logic          cfg_we;
    logic [CW+23:0] rank_prod;
    logic [CW-1:0] nm1;

    logic [32:0] upper;
    logic [32:0] lower;
    logic [33:0] rem_sh;
    logic [34:0] dsub;
    logic        dge;

    logic [32:0] med_diff;
    logic [32:0] med_abs;
    logic        med_hit;
    logic [32:0] skw_diff;
    logic [32:0] skw_abs;
    logic        skw_hit;
    logic        med_flag;
    logic        skw_flag;
    logic [31:0] shift_cnt_next;
    logic        load_out;

    always_comb
    begin
        w_eff = EW'(win_size_reg);
        if (w_eff > MAXW)
        begin
            w_eff = MAXW;
        end
        if (w_eff < MINW)
        begin
            w_eff = MINW;
        end
        need = (min_fill_reg < 7'd2) ? EW'(2) : EW'(min_fill_reg);
    end

    assign fill_ext  = EW'(fill_reg);
    assign fill_next = (fill_ext < w_eff) ? fill_reg + CW'(1) : fill_reg;
    assign wp_inc    = EW'(wp_reg) + EW'(1);
    assign wp_next   = (wp_inc == w_eff) ? '0 : wp_inc[AW-1:0];

    assign sample_stall = (state_reg != S_IDLE) || cfg_valid;
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign cfg_we       = cfg_valid && cfg_ready;
    assign ram_we       = accept;

    assign nm1       = fill_reg - CW'(1);
    assign rank_prod = (CW+24)'(nm1) * (CW+24)'(pct_mult(k_reg));

    always_comb
    begin
        case (state_reg)
            S_CRD:   ram_raddr = i_reg[AW-1:0];
            S_SCAN:  ram_raddr = j_reg[AW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    swqt_ram #(
        .WIDTH(32),
        .DEPTH(MAX_WINDOW)
    ) u_window (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(sample),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign upper  = {q_reg[3][31], q_reg[3]} - {q_reg[2][31], q_reg[2]};
    assign lower  = {q_reg[2][31], q_reg[2]} - {q_reg[1][31], q_reg[1]};
    assign rem_sh = {rem_reg, quo_reg[47]};
    assign dsub   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign dge    = !dsub[34];

    assign med_diff = {q_reg[2][31], q_reg[2]} - {ref_med_reg[31], ref_med_reg};
    assign med_abs  = med_diff[32] ? (33'd0 - med_diff) : med_diff;
    assign med_hit  = med_abs > {2'b00, med_thr_reg};
    assign skw_diff = {1'b0, skew_reg} - {1'b0, ref_skew_reg};
    assign skw_abs  = skw_diff[32] ? (33'd0 - skw_diff) : skw_diff;
    assign skw_hit  = skw_abs > {2'b00, skew_thr_reg};
    assign med_flag = seeded_reg && med_hit;
    assign skw_flag = seeded_reg && skw_hit;
    assign shift_cnt_next = (med_flag && (shift_cnt_reg != CNT_MAX)) ?
                            shift_cnt_reg + 32'd1 : shift_cnt_reg;
    assign load_out = (state_reg == S_FIN) && (!result_valid || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_size_reg  <= 7'd64;
            min_fill_reg  <= 7'd8;
            med_thr_reg   <= 31'd655;
            skew_thr_reg  <= 31'd32768;
            wp_reg        <= '0;
            fill_reg      <= '0;
            seeded_reg    <= 1'b0;
            ref_med_reg   <= '0;
            ref_skew_reg  <= ONE_Q16;
            for (int k = 0; k < NUM_Q; k++)
            begin
                q_reg[k]    <= '0;
                rank_reg[k] <= '0;
            end
            skew_reg      <= ONE_Q16;
            total_reg     <= '0;
            shift_cnt_reg <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            lt_reg        <= '0;
            le_reg        <= '0;
            cand_reg      <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dvs_reg       <= '0;
            dcnt_reg      <= '0;
            q10           <= '0;
            q25           <= '0;
            q50           <= '0;
            q75           <= '0;
            q90           <= '0;
            skew_q16      <= '0;
            median_shift  <= 1'b0;
            old_median    <= '0;
            skew_change   <= 1'b0;
            shift_count   <= '0;
            sample_count  <= '0;
            result_valid  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:
                    begin
                        win_size_reg <= cfg_data[6:0];
                        wp_reg       <= '0;
                        fill_reg     <= '0;
                        seeded_reg   <= 1'b0;
                        ref_med_reg  <= '0;
                        ref_skew_reg <= ONE_Q16;
                    end
                    REG_MIN_FILL: min_fill_reg <= cfg_data[6:0];
                    REG_MED_THR:  med_thr_reg  <= cfg_data[30:0];
                    REG_SKEW_THR: skew_thr_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (load_out)
            begin
                result_valid <= 1'b1;
            end
            else if (result_valid && !result_stall)
            begin
                result_valid <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (total_reg != CNT_MAX)
                        begin
                            total_reg <= total_reg + 32'd1;
                        end
                        fill_reg <= fill_next;
                        wp_reg   <= wp_next;
                        k_reg    <= '0;
                        state_reg <= (EW'(fill_next) >= need) ? S_RANK : S_FIN;
                    end
                end
                S_RANK:
                begin
                    rank_reg[k_reg] <= rank_prod[CW+23:24];
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'(NUM_Q - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CCAP;
                end
                S_CCAP:
                begin
                    cand_reg  <= ram_rdata;
                    j_reg     <= '0;
                    lt_reg    <= '0;
                    le_reg    <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (j_reg != '0)
                    begin
                        if ($signed(ram_rdata) < cand_reg)
                        begin
                            lt_reg <= lt_reg + CW'(1);
                        end
                        if ($signed(ram_rdata) <= cand_reg)
                        begin
                            le_reg <= le_reg + CW'(1);
                        end
                    end
                    j_reg <= j_reg + CW'(1);
                    if (j_reg == fill_reg)
                    begin
                        state_reg <= S_CEVAL;
                    end
                end
                S_CEVAL:
                begin
                    for (int k = 0; k < NUM_Q; k++)
                    begin
                        if ((lt_reg <= rank_reg[k]) && (rank_reg[k] < le_reg))
                        begin
                            q_reg[k] <= cand_reg;
                        end
                    end
                    i_reg <= i_reg + CW'(1);
                    state_reg <= (i_reg + CW'(1) == fill_reg) ? S_DINIT : S_CRD;
                end
                S_DINIT:
                begin
                    quo_reg   <= {upper[31:0], 16'd0};
                    dvs_reg   <= {1'b0, lower[31:0]} + 33'd1;
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= dge ? dsub[32:0] : rem_sh[32:0];
                    quo_reg  <= {quo_reg[46:0], dge};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd47)
                    begin
                        state_reg <= S_SKEW;
                    end
                end
                S_SKEW:
                begin
                    skew_reg  <= (quo_reg[47:32] != 16'd0) ? CNT_MAX : quo_reg[31:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (load_out)
                    begin
                        median_shift  <= med_flag;
                        skew_change   <= skw_flag;
                        old_median    <= med_flag ? ref_med_reg : '0;
                        shift_cnt_reg <= shift_cnt_next;
                        shift_count   <= shift_cnt_next;
                        if (!seeded_reg || med_hit)
                        begin
                            ref_med_reg <= q_reg[2];
                        end
                        if (!seeded_reg || skw_hit)
                        begin
                            ref_skew_reg <= skew_reg;
                        end
                        seeded_reg   <= 1'b1;
                        q10          <= q_reg[0];
                        q25          <= q_reg[1];
                        q50          <= q_reg[2];
                        q75          <= q_reg[3];
                        q90          <= q_reg[4];
                        skew_q16     <= skew_reg;
                        sample_count <= total_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_ext <= w_eff)
        else $error("fill count beyond window");

    assert property (@(posedge clk) disable iff (!rst_n) EW'(wp_reg) < w_eff)
        else $error("write pointer beyond window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg <= fill_reg))
        else $error("scan index beyond fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item left no work");

endmodule

`default_nettype wire

// ===== tb/sliding_window_quantile_tracker_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_quantile_tracker_core: random and directed
// samples and register settings, with a built-in tracker model predicting every result.
// Depends on swqt_pkg and the core RTL only.

module sliding_window_quantile_tracker_core_tb;
    import swqt_pkg::*;

    localparam int WIN_MAX  = 64;
    localparam int WD_LIMIT = 40000;

    typedef struct {
        logic signed [31:0] q [NUM_Q];
        logic [31:0]        skew;
        logic               mshift;
        logic signed [31:0] omed;
        logic               schange;
        logic [31:0]        shifts;
        logic [31:0]        total;
    } track_result_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic signed [31:0] sample;
    logic result_valid;
    logic result_stall;
    logic signed [31:0] q10, q25, q50, q75, q90;
    logic [31:0] skew_q16;
    logic median_shift;
    logic signed [31:0] old_median;
    logic skew_change;
    logic [31:0] shift_count;
    logic [31:0] sample_count;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    sliding_window_quantile_tracker_core #(.MAX_WINDOW(WIN_MAX)) dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall),
        .q10(q10), .q25(q25), .q50(q50), .q75(q75), .q90(q90),
        .skew_q16(skew_q16), .median_shift(median_shift), .old_median(old_median),
        .skew_change(skew_change), .shift_count(shift_count), .sample_count(sample_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // tracker model state
    logic [6:0]         m_win_size;
    logic [6:0]         m_min_fill;
    logic [30:0]        m_med_thr;
    logic [30:0]        m_skew_thr;
    logic signed [31:0] m_store [WIN_MAX];
    int unsigned        m_wptr;
    int unsigned        m_fill;
    bit                 m_seeded;
    logic signed [31:0] m_ref_med;
    logic [31:0]        m_ref_skew;
    logic signed [31:0] m_held_q [NUM_Q];
    logic [31:0]        m_held_skew;
    logic [31:0]        m_total;
    logic [31:0]        m_shifts;

    logic [31:0]   pending_samples [$];
    track_result_t expected_results [$];
    int  idle_mode;
    int  errors;
    int  sent_count;
    int  recv_count;
    int  shift_seen;
    int  skew_seen;
    int  cfg_count;
    int  quiet_cycles;
    bit  sample_taken;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned eff_window();
        int unsigned w;
        w = m_win_size;
        if (w > WIN_MAX) w = WIN_MAX;
        if (w < 8) w = 8;
        return w;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WIN_MAX; i++) m_store[i] = '0;
        m_wptr    = 0;
        m_fill    = 0;
        m_seeded  = 1'b0;
        m_ref_med = '0;
        m_ref_skew = ONE_Q16;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            REG_WINDOW_SIZE:
            begin
                m_win_size = data[6:0];
                clear_window();
            end
            REG_MIN_FILL: m_min_fill = data[6:0];
            REG_MED_THR:  m_med_thr  = data[30:0];
            REG_SKEW_THR: m_skew_thr = data[30:0];
            default: ;
        endcase
    endfunction

    function automatic void refresh_quantiles(int unsigned w);
        logic signed [31:0] srt [WIN_MAX];
        logic signed [31:0] v;
        int unsigned need;
        int unsigned pos;
        int j;
        longint upper;
        longint lower;
        longint unsigned ratio;
        int unsigned pct [NUM_Q];
        pct = '{10, 25, 50, 75, 90};
        need = (m_min_fill < 2) ? 2 : m_min_fill;
        if (m_fill < need || m_fill > w) return;
        for (int i = 0; i < m_fill; i++) srt[i] = m_store[(m_wptr + 2 * w - m_fill + i) % w];
        for (int i = 1; i < m_fill; i++)
        begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j - 1] > v)
            begin
                srt[j] = srt[j - 1];
                j--;
            end
            srt[j] = v;
        end
        for (int k = 0; k < NUM_Q; k++)
        begin
            pos = ((m_fill - 1) * pct[k]) / 100;
            m_held_q[k] = srt[pos];
        end
        upper = longint'(m_held_q[3]) - longint'(m_held_q[2]);
        lower = longint'(m_held_q[2]) - longint'(m_held_q[1]);
        if (upper < 0) upper = 0;
        if (lower < 0) lower = 0;
        ratio = (longint'(upper) <<< 16) / (lower + 1);
        m_held_skew = (ratio > 64'hFFFF_FFFF) ? CNT_MAX : ratio[31:0];
    endfunction

    function automatic track_result_t track_sample(logic signed [31:0] s);
        track_result_t r;
        int unsigned w;
        longint dm;
        longint ds;
        w = eff_window();
        r.mshift  = 1'b0;
        r.schange = 1'b0;
        r.omed    = '0;
        if (m_total != CNT_MAX) m_total++;
        if (m_wptr >= w) m_wptr = 0;
        if (m_fill < w) m_fill++;
        m_store[m_wptr] = s;
        m_wptr = (m_wptr + 1) % w;
        refresh_quantiles(w);
        if (!m_seeded)
        begin
            m_ref_med  = m_held_q[2];
            m_ref_skew = m_held_skew;
            m_seeded   = 1'b1;
        end
        else
        begin
            dm = longint'(m_held_q[2]) - longint'(m_ref_med);
            ds = longint'({32'd0, m_held_skew}) - longint'({32'd0, m_ref_skew});
            if (dm < 0) dm = -dm;
            if (ds < 0) ds = -ds;
            if (dm > longint'({33'd0, m_med_thr}))
            begin
                r.omed    = m_ref_med;
                r.mshift  = 1'b1;
                m_ref_med = m_held_q[2];
                if (m_shifts != CNT_MAX) m_shifts++;
            end
            if (ds > longint'({33'd0, m_skew_thr}))
            begin
                r.schange  = 1'b1;
                m_ref_skew = m_held_skew;
            end
        end
        r.q      = m_held_q;
        r.skew   = m_held_skew;
        r.shifts = m_shifts;
        r.total  = m_total;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver: change inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_valid || sample_taken)
            begin
                if (pending_samples.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 88) ||
                      (idle_mode == 3 && $urandom_range(99) < 11)))
                begin
                    sample       = pending_samples.pop_front();
                    sample_valid = 1'b1;
                end
                else
                    sample_valid = 1'b0;
            end
            result_stall = (idle_mode == 2 && $urandom_range(99) < 88) ||
                           (idle_mode == 3 && $urandom_range(99) < 11);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge clk)
    begin
        track_result_t e;
        sample_taken = 1'b0;
        if (rst_n)
        begin
            quiet_cycles++;
            if (sample_valid && !sample_stall)
            begin
                sample_taken = 1'b1;
                expected_results.push_back(track_sample(sample));
                sent_count++;
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready) quiet_cycles = 0;
            if (result_valid && !result_stall)
            begin
                quiet_cycles = 0;
                recv_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("q10", e.q[0], q10);
                    check_field("q25", e.q[1], q25);
                    check_field("q50", e.q[2], q50);
                    check_field("q75", e.q[3], q75);
                    check_field("q90", e.q[4], q90);
                    check_field("skew_q16", e.skew, skew_q16);
                    check_field("median_shift", {31'd0, e.mshift}, {31'd0, median_shift});
                    check_field("old_median", e.omed, old_median);
                    check_field("skew_change", {31'd0, e.schange}, {31'd0, skew_change});
                    check_field("shift_count", e.shifts, shift_count);
                    check_field("sample_count", e.total, sample_count);
                    shift_seen += e.mshift;
                    skew_seen  += e.schange;
                end
            end
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no handshake in %0d cycles", WD_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_samples.size() > 0 || expected_results.size() > 0 || sample_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
        cfg_count++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_sample(logic [31:0] base);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return $urandom();
        if (pick < 65) return base + $urandom_range(4000) - 2000;
        if (pick < 80) return base + ($urandom_range(8) << 16);
        return base;
    endfunction

    task automatic run_items(int count);
        logic [31:0] base;
        base = $urandom();
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(19) == 0) base = $urandom();
            if ($urandom_range(9) == 0) base = base + ($urandom_range(20) << 14);
            pending_samples.push_back(rand_sample(base));
        end
        drain();
    endtask

    initial
    begin
        int unsigned wsel;
        int items;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_mode = 0;
        errors = 0;
        sent_count = 0;
        recv_count = 0;
        shift_seen = 0;
        skew_seen = 0;
        cfg_count = 0;
        quiet_cycles = 0;
        sample_taken = 1'b0;
        m_win_size = 7'd64;
        m_min_fill = 7'd8;
        m_med_thr = 31'd655;
        m_skew_thr = 31'd32768;
        clear_window();
        for (int k = 0; k < NUM_Q; k++) m_held_q[k] = '0;
        m_held_skew = ONE_Q16;
        m_total = '0;
        m_shifts = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, full window, extremes first
        pending_samples.push_back(32'h7FFF_FFFF);
        pending_samples.push_back(32'h8000_0000);
        pending_samples.push_back(32'h0000_0000);
        pending_samples.push_back(32'hFFFF_FFFF);
        pending_samples.push_back(32'h0000_0001);
        pending_samples.push_back(32'h7FFF_FFFF);
        pending_samples.push_back(32'h8000_0000);
        pending_samples.push_back(32'h5555_5555);
        pending_samples.push_back(32'hAAAA_AAAA);
        drain();
        run_items(60);

        // min fill beyond the window, out-of-range window codes, unknown index
        write_register(REG_WINDOW_SIZE, 32'hFFFF_FF80);
        write_register(REG_MIN_FILL, 32'h0000_007F);
        write_register(REG_MED_THR, 32'h0000_0000);
        write_register(REG_SKEW_THR, 32'h0000_0000);
        write_register(8'hFF, 32'hFFFF_FFFF);
        run_items(12);
        write_register(REG_MIN_FILL, 32'hFFFF_FF00);
        write_register(REG_MED_THR, 32'hFFFF_FFFF);
        write_register(REG_SKEW_THR, 32'hFFFF_FFFF);
        run_items(12);
        write_register(REG_WINDOW_SIZE, 32'h0000_007F);
        write_register(REG_MIN_FILL, 32'h0000_0001);
        run_items(8);

        for (int ph = 0; ph < 26; ph++)
        begin
            idle_mode = ph % 4;
            wsel = $urandom_range(19);
            if (wsel == 0)
                write_register(REG_WINDOW_SIZE, ($urandom() & 32'hFFFF_FF80) | 32'd64);
            else if (wsel == 1)
                write_register(REG_WINDOW_SIZE, ($urandom() & 32'hFFFF_FF80) | $urandom_range(7));
            else
                write_register(REG_WINDOW_SIZE, ($urandom() & 32'hFFFF_FF80) | $urandom_range(8, 16));
            case ($urandom_range(4))
                0: write_register(REG_MIN_FILL, $urandom() & 32'hFFFF_FF80);
                1: write_register(REG_MIN_FILL, ($urandom() & 32'hFFFF_FF80) | 32'd2);
                2: write_register(REG_MIN_FILL, ($urandom() & 32'hFFFF_FF80) | 32'd127);
                default: write_register(REG_MIN_FILL, $urandom_range(16));
            endcase
            case ($urandom_range(3))
                0: write_register(REG_MED_THR, 32'd0);
                1: write_register(REG_MED_THR, 32'h7FFF_FFFF);
                2: write_register(REG_MED_THR, $urandom_range(70000));
                default: write_register(REG_MED_THR, $urandom());
            endcase
            case ($urandom_range(3))
                0: write_register(REG_SKEW_THR, 32'd0);
                1: write_register(REG_SKEW_THR, 32'hFFFF_FFFF);
                2: write_register(REG_SKEW_THR, $urandom_range(200000));
                default: write_register(REG_SKEW_THR, $urandom());
            endcase
            items = (wsel == 0) ? 20 : 58;
            run_items(items);
        end

        drain();
        repeat (200) @(posedge clk);
        $display("run covered %0d samples, %0d results, %0d register writes",
                 sent_count, recv_count, cfg_count);
        $display("flagged %0d median shifts and %0d skew changes", shift_seen, skew_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
